>>> sv/sck_pkg.sv
package sck_pkg;

  // configuration register indexes and field widths
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned ImageWidthW  = 12;
  localparam int unsigned ImageHeightW = 16;
  localparam int unsigned PixelColW    = 11;

  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 1'b1;

  localparam logic [ImageWidthW-1:0]  ImageWidthReset  = 12'd640;
  localparam logic [ImageHeightW-1:0] ImageHeightReset = 16'd480;

  localparam int unsigned MaxWidthDefault = 2048;

  // one rgb pixel as kept in the line stores
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // input word
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [7:0]              red_out;
    logic [7:0]              green_out;
    logic [7:0]              blue_out;
    logic [ImageHeightW-1:0] pixel_row;
    logic [PixelColW-1:0]    pixel_col;
    logic                    run_last;
  } out_word_t;

endpackage

>>> sv/sck_line_mem.sv
module sck_line_mem import sck_pkg::*; #(
  parameter int unsigned Depth = MaxWidthDefault,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic [AddrW-1:0] rd_addr_right_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  pixel_t           wr_cur_i,
  input  pixel_t           wr_ctr_i,
  output pixel_t           up_o,
  output pixel_t           ctr_o,
  output pixel_t           right_o
);

  // row above and row two above the incoming pixel
  pixel_t prev_mem  [Depth];
  pixel_t prev2_mem [Depth];

  pixel_t up_q, ctr_q, right_q;

  // write back and registered reads, forwarding a write of the same edge
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      prev_mem[wr_addr_i]  <= wr_cur_i;
      prev2_mem[wr_addr_i] <= wr_ctr_i;
    end
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        ctr_q <= wr_cur_i;
        up_q  <= wr_ctr_i;
      end else begin
        ctr_q <= prev_mem[rd_addr_i];
        up_q  <= prev2_mem[rd_addr_i];
      end
      if (wr_en_i && (wr_addr_i == rd_addr_right_i)) begin
        right_q <= wr_cur_i;
      end else begin
        right_q <= prev_mem[rd_addr_right_i];
      end
    end
  end

  assign up_o    = up_q;
  assign ctr_o   = ctr_q;
  assign right_o = right_q;

endmodule

>>> sv/sck_kernel.sv
module sck_kernel import sck_pkg::*; (
  input  pixel_t up_i,
  input  pixel_t ctr_i,
  input  pixel_t left_i,
  input  pixel_t right_i,
  input  pixel_t down_i,
  output pixel_t res_o
);

  // 5*centre minus the four cross neighbours, clamped to 0..255
  function automatic logic [7:0] sharpen_chan(input logic [7:0] ctr, input logic [7:0] up,
                                               input logic [7:0] lft, input logic [7:0] rgt,
                                               input logic [7:0] dwn);
    logic signed [11:0] acc;
    logic [7:0]         res;
    acc = $signed({2'b00, ctr, 2'b00}) + $signed({4'b0000, ctr})
        - $signed({4'b0000, up}) - $signed({4'b0000, lft})
        - $signed({4'b0000, rgt}) - $signed({4'b0000, dwn});
    if (acc < 12'sd0) begin
      res = 8'd0;
    end else if (acc > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = acc[7:0];
    end
    return res;
  endfunction

  assign res_o.red   = sharpen_chan(ctr_i.red, up_i.red, left_i.red, right_i.red, down_i.red);
  assign res_o.green = sharpen_chan(ctr_i.green, up_i.green, left_i.green, right_i.green,
                                    down_i.green);
  assign res_o.blue  = sharpen_chan(ctr_i.blue, up_i.blue, left_i.blue, right_i.blue,
                                    down_i.blue);

endmodule

>>> sv/sharpen_cross_kernel_filter.sv
// channel  dir  valid        stall         payload
// in       in   in_valid_i   in_stall_o    in_data_i  (in_word_t)
// out      out  out_valid_o  out_stall_i   out_data_o (out_word_t)
// cfg      in   cfg_we_i     -             cfg_idx_i, cfg_wdata_i
//
// one word per cycle while the output does not stall: line store read at accept, kernel
// and write back from the work stage after it, result into the output register.
// a final-row word with a row above gives two results and holds the input until both
// are loaded, since the single output register takes one result per cycle.
// reset clears counters and handshake state; line stores hold garbage until written.
// input stall follows output stall combinationally through the output register.
module sharpen_cross_kernel_filter import sck_pkg::*; #(
  parameter int unsigned MaxWidth = MaxWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_data_o
);

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned EffW = ColW + 1;
  localparam int unsigned CmpW = (ImageWidthW > EffW) ? ImageWidthW : EffW;

  // configuration
  logic [ImageWidthW-1:0]  img_w_q;
  logic [ImageHeightW-1:0] img_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= ImageWidthReset;
      img_h_q <= ImageHeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgImageWidth:  img_w_q <= cfg_wdata_i[ImageWidthW-1:0];
        CfgImageHeight: img_h_q <= cfg_wdata_i[ImageHeightW-1:0];
        default:        img_w_q <= img_w_q;
      endcase
    end
  end

  // effective geometry
  logic [CmpW-1:0]         w_eff;
  logic [ImageHeightW-1:0] h_eff;

  always_comb begin
    if (img_w_q == '0) begin
      w_eff = CmpW'(1);
    end else if (CmpW'(img_w_q) > CmpW'(MaxWidth)) begin
      w_eff = CmpW'(MaxWidth);
    end else begin
      w_eff = CmpW'(img_w_q);
    end
    h_eff = (img_h_q == '0) ? ImageHeightW'(1) : img_h_q;
  end

  // position counters
  logic [ColW-1:0]         col_q, col_d;
  logic [ImageHeightW-1:0] row_q, row_d;
  logic [ColW-1:0]         cur_col, rd_right;
  logic [ImageHeightW-1:0] cur_row, row_nxt;
  logic                    last_col, final_row, in_accept;

  always_comb begin
    cur_col   = (CmpW'(col_q) >= w_eff) ? '0 : col_q;
    cur_row   = (row_q >= h_eff) ? '0 : row_q;
    last_col  = (CmpW'(cur_col) + CmpW'(1)) >= w_eff;
    final_row = ({1'b0, cur_row} + 17'd1) == {1'b0, h_eff};
    row_nxt   = final_row ? '0 : cur_row + ImageHeightW'(1);
    rd_right  = last_col ? cur_col : cur_col + ColW'(1);
    col_d     = col_q;
    row_d     = row_q;
    if (in_accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = row_nxt;
      end else begin
        col_d = cur_col + ColW'(1);
        row_d = cur_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // work stage holding the accepted word
  logic                    s1_valid_q, s1_valid_d;
  logic                    phase_q, phase_d;
  pixel_t                  s1_cur_q;
  logic [ImageHeightW-1:0] s1_row_q;
  logic [ColW-1:0]         s1_col_q;
  logic                    s1_has_a_q, s1_has_b_q, s1_interior_q;
  pixel_t                  left_q;
  pixel_t                  in_pix;

  assign in_pix = '{red: in_data_i.red_in, green: in_data_i.green_in,
                    blue: in_data_i.blue_in};

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cur_q      <= in_pix;
      s1_row_q      <= cur_row;
      s1_col_q      <= cur_col;
      s1_has_a_q    <= (cur_row != '0);
      s1_has_b_q    <= final_row;
      s1_interior_q <= (cur_row >= ImageHeightW'(2))
                    && (cur_col != '0) && !last_col;
    end
  end

  // line stores
  pixel_t up, ctr, right, sharp;
  logic   s1_retire;

  sck_line_mem #(
    .Depth (MaxWidth),
    .AddrW (ColW)
  ) u_line_mem (
    .clk_i           (clk_i),
    .rd_en_i         (in_accept),
    .rd_addr_i       (cur_col),
    .rd_addr_right_i (rd_right),
    .wr_en_i         (s1_retire),
    .wr_addr_i       (s1_col_q),
    .wr_cur_i        (s1_cur_q),
    .wr_ctr_i        (ctr),
    .up_o            (up),
    .ctr_o           (ctr),
    .right_o         (right)
  );

  // left neighbour is the centre of the previous word in the row
  always_ff @(posedge clk_i) begin
    if (s1_retire) begin
      left_q <= ctr;
    end
  end

  sck_kernel u_kernel (
    .up_i    (up),
    .ctr_i   (ctr),
    .left_i  (left_q),
    .right_i (right),
    .down_i  (s1_cur_q),
    .res_o   (sharp)
  );

  // result sequencing: row-above result first, own pixel second
  logic      out_valid_q, out_valid_d;
  out_word_t out_data_q;
  logic      out_free, send_a, cur_last, has_any, out_load;
  pixel_t    res_a;

  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    send_a     = s1_has_a_q && !phase_q;
    cur_last   = send_a ? !s1_has_b_q : 1'b1;
    has_any    = s1_has_a_q || s1_has_b_q;
    out_load   = s1_valid_q && has_any && out_free;
    s1_retire  = s1_valid_q && (!has_any || (out_free && cur_last));
    in_stall_o = s1_valid_q && !s1_retire;
    in_accept  = in_valid_i && !in_stall_o;
    res_a      = s1_interior_q ? sharp : ctr;

    s1_valid_d = in_accept ? 1'b1 : (s1_retire ? 1'b0 : s1_valid_q);
    phase_d    = phase_q;
    if (s1_retire) begin
      phase_d = 1'b0;
    end else if (out_load && send_a) begin
      phase_d = 1'b1;
    end
    out_valid_d = out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (send_a) begin
        out_data_q.red_out   <= res_a.red;
        out_data_q.green_out <= res_a.green;
        out_data_q.blue_out  <= res_a.blue;
        out_data_q.pixel_row <= s1_row_q - ImageHeightW'(1);
      end else begin
        out_data_q.red_out   <= s1_cur_q.red;
        out_data_q.green_out <= s1_cur_q.green;
        out_data_q.blue_out  <= s1_cur_q.blue;
        out_data_q.pixel_row <= s1_row_q;
      end
      out_data_q.pixel_col <= PixelColW'(s1_col_q);
      out_data_q.run_last  <= cur_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pixel_row < h_eff))
    else $error("result row beyond frame height");

  a_partner_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.run_last) |-> (s1_valid_q && phase_q && s1_has_b_q))
    else $error("non-last result without its partner in the work stage");

  a_phase_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (s1_valid_q && s1_has_a_q && s1_has_b_q))
    else $error("second-result phase without a two-result word");

endmodule

>>> dv/sharpen_cross_kernel_filter_tb.sv
`timescale 1ns / 1ps

import sck_pkg::*;

// predicts sharpened pixels from accepted words and checks returned words in order
class sharpen_board;
  localparam int unsigned MaxW = MaxWidthDefault;

  logic [ImageWidthW-1:0]  width_reg;
  logic [ImageHeightW-1:0] height_reg;
  pixel_t                  line_above[MaxW];
  pixel_t                  line_two_above[MaxW];
  int unsigned             next_col;
  int unsigned             next_row;
  out_word_t               pending_pixels[$];
  int unsigned             mismatches;

  function new();
    width_reg  = ImageWidthReset;
    height_reg = ImageHeightReset;
    next_col   = 0;
    next_row   = 0;
    mismatches = 0;
  endfunction

  function void set_geometry(logic [CfgDataW-1:0] w_data, logic [CfgDataW-1:0] h_data);
    width_reg  = w_data[ImageWidthW-1:0];
    height_reg = h_data[ImageHeightW-1:0];
  endfunction

  // 5*centre minus the cross, clamped to a byte
  function automatic logic [7:0] sharpen_channel(logic [7:0] mid, logic [7:0] up,
                                                 logic [7:0] lft, logic [7:0] rgt,
                                                 logic [7:0] below);
    int acc;
    acc = 5 * int'(mid) - int'(up) - int'(lft) - int'(rgt) - int'(below);
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return acc[7:0];
  endfunction

  function void note_result(pixel_t px, logic [15:0] row, logic [10:0] col, logic last);
    out_word_t want;
    want.red_out   = px.red;
    want.green_out = px.green;
    want.blue_out  = px.blue;
    want.pixel_row = row;
    want.pixel_col = col;
    want.run_last  = last;
    pending_pixels.push_back(want);
  endfunction

  // one accepted input word
  function void take_pixel(in_word_t word);
    int unsigned wd, ht, c, r;
    pixel_t      cur, up, ctr, lft, rgt, res;
    bit          last_row;
    wd = (width_reg == 0) ? 1 : int'(width_reg);
    if (wd > MaxW) wd = MaxW;
    ht = (height_reg == 0) ? 1 : int'(height_reg);
    // counters beyond a shrunk geometry restart
    if (next_col >= wd) next_col = 0;
    if (next_row >= ht) next_row = 0;
    c        = next_col;
    r        = next_row;
    last_row = (r + 1 == ht);
    cur      = word;
    up       = line_two_above[c];
    ctr      = line_above[c];
    lft      = (c >= 1) ? line_two_above[c-1] : '0;
    rgt      = (c + 1 < wd) ? line_above[c+1] : '0;

    // result for the pixel one row up
    if (r >= 1) begin
      res = ctr;
      if (r >= 2 && c >= 1 && c + 2 <= wd) begin
        res.red   = sharpen_channel(ctr.red, up.red, lft.red, rgt.red, cur.red);
        res.green = sharpen_channel(ctr.green, up.green, lft.green, rgt.green, cur.green);
        res.blue  = sharpen_channel(ctr.blue, up.blue, lft.blue, rgt.blue, cur.blue);
      end
      note_result(res, 16'(r - 1), 11'(c), !last_row);
    end
    // final row also passes its own border pixel
    if (last_row) begin
      note_result(cur, 16'(r), 11'(c), 1'b1);
    end

    line_two_above[c] = line_above[c];
    line_above[c]     = cur;

    if (c + 1 >= wd) begin
      next_col = 0;
      next_row = (r + 1 >= ht) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
  endfunction

  function void compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // one returned output word against the oldest prediction
  function void check_word(out_word_t got);
    out_word_t want;
    if (pending_pixels.size() == 0) begin
      $error("word with nothing pending: row %0d col %0d", got.pixel_row, got.pixel_col);
      mismatches++;
      return;
    end
    want = pending_pixels.pop_front();
    compare_field("red_out", 16'(want.red_out), 16'(got.red_out));
    compare_field("green_out", 16'(want.green_out), 16'(got.green_out));
    compare_field("blue_out", 16'(want.blue_out), 16'(got.blue_out));
    compare_field("pixel_row", want.pixel_row, got.pixel_row);
    compare_field("pixel_col", 16'(want.pixel_col), 16'(got.pixel_col));
    compare_field("run_last", 16'(want.run_last), 16'(got.run_last));
  endfunction
endclass

module sharpen_cross_kernel_filter_tb;

  localparam int unsigned ClkPeriod    = 20;
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomPixels = 1700;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  in_word_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_word_t           out_data_o;

  sharpen_board board;
  bit           calm;
  int unsigned  pixels_sent;
  int unsigned  hold_left;
  int unsigned  stall_draw;
  int unsigned  cycle_count;

  sharpen_cross_kernel_filter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // watch both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.take_pixel(in_data_i);
      if (out_valid_o && !out_stall_i) board.check_word(out_data_o);
    end
  end

  // output side: random stall after each word
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      stall_draw = calm ? 0 : $urandom_range(0, 13);
      hold_left   <= stall_draw;
      out_stall_i <= (stall_draw != 0);
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= (hold_left > 1);
    end
  end

  function automatic int unsigned eff_width(logic [ImageWidthW-1:0] w);
    if (w == 0) return 1;
    if (w > MaxWidthDefault) return MaxWidthDefault;
    return w;
  endfunction

  function automatic int unsigned eff_height(logic [ImageHeightW-1:0] h);
    return (h == 0) ? 1 : h;
  endfunction

  function automatic in_word_t rand_pixel();
    logic [31:0] raw;
    in_word_t    px;
    raw = $urandom();
    px  = raw[23:0];
    if ($urandom_range(0, 5) == 0) px.red_in = {8{raw[24]}};
    if ($urandom_range(0, 5) == 0) px.green_in = {8{raw[25]}};
    if ($urandom_range(0, 5) == 0) px.blue_in = {8{raw[26]}};
    return px;
  endfunction

  // present one word and hold it until taken
  task automatic send_pixel(input in_word_t px);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pixels_sent++;
  endtask

  task automatic send_pixels(input int unsigned count);
    repeat (count) send_pixel(rand_pixel());
  endtask

  // stop sending until every predicted word is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write both geometry registers while idle; spare width bits get noise
  task automatic set_geometry(input logic [ImageWidthW-1:0] width,
                              input logic [ImageHeightW-1:0] height);
    logic [CfgDataW-1:0] wdata;
    drain_results();
    wdata = CfgDataW'($urandom());
    wdata[ImageWidthW-1:0] = width;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgImageWidth;
    cfg_wdata_i <= wdata;
    @(posedge clk_i);
    cfg_idx_i   <= CfgImageHeight;
    cfg_wdata_i <= height;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_geometry(wdata, height);
  endtask

  initial begin
    int unsigned w, h, k, rows, random_start;
    board = new();
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CfgImageWidth;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    calm         = 1'b0;
    pixels_sent  = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x3 frames: bright centre clamps high, dark centre clamps low
    set_geometry(3, 3);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 24'hFF00C8 : 24'h00FF00);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 24'h000000 : 24'hFFFFFF);

    // single row: first row is also the final row
    set_geometry(2, 1);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);

    // zero sizes act as one pixel
    set_geometry(0, 0);
    send_pixels(2);

    // two rows: final row gives two words per input
    set_geometry(3, 2);
    send_pixels(6);

    // oversized width acts as the maximum, start of one row
    calm = 1'b1;
    set_geometry(12'hFFF, 1);
    send_pixels(40);

    random_start = pixels_sent;
    while (pixels_sent - random_start < RandomPixels) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          // tall frame cut short by shrinking the height at a row start
          w    = $urandom_range(1, 8);
          rows = $urandom_range(2, 6);
          h    = $urandom_range(0, 1) ? 65535 : $urandom_range(rows + 1, 65535);
          set_geometry(ImageWidthW'(w), ImageHeightW'(h));
          send_pixels(w * rows);
          w = $urandom_range(0, 10);
          h = $urandom_range(0, rows);
          set_geometry(ImageWidthW'(w), ImageHeightW'(h));
          send_pixels(eff_width(ImageWidthW'(w)) * eff_height(ImageHeightW'(h)));
        end
        2: begin
          // wide row cut short by shrinking the width within the first row
          case ($urandom_range(0, 2))
            0:       w = MaxWidthDefault;
            1:       w = 12'hFFF;
            default: w = $urandom_range(13, MaxWidthDefault - 1);
          endcase
          set_geometry(ImageWidthW'(w), ImageHeightW'($urandom_range(1, 8)));
          k = $urandom_range(1, 12);
          send_pixels(k);
          w = $urandom_range(0, k);
          h = $urandom_range(1, 8);
          set_geometry(ImageWidthW'(w), ImageHeightW'(h));
          send_pixels(eff_width(ImageWidthW'(w)) * h);
        end
        default: begin
          // whole frames of a small geometry
          w = $urandom_range(0, 12);
          h = $urandom_range(0, 8);
          set_geometry(ImageWidthW'(w), ImageHeightW'(h));
          send_pixels(eff_width(ImageWidthW'(w)) * eff_height(ImageHeightW'(h))
                      * $urandom_range(1, 3));
        end
      endcase
    end

    drain_results();
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
